FILE: sv/gclp_pkg.sv
// gclp_pkg: character codes, field widths and result codes for the g-code line parser
// no dependencies; imported by gcode_line_parser, gclp_checker and tb_top
package gclp_pkg;

  // field widths
  localparam int CODE_W  = 13;
  localparam int AMODE_W = 2;
  localparam int COORD_W = 38;

  // default geometry
  localparam int LINE_CHARS_DEF  = 32;
  localparam int TOKEN_CHARS_DEF = 9;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_1     = 8'd49;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_M     = 8'd77;

  // command code offsets
  localparam int CODE_OFS_G = 900;
  localparam int CODE_OFS_M = 100;

  // a mode codes
  localparam logic [AMODE_W-1:0] AMODE_NONE = 2'd0;
  localparam logic [AMODE_W-1:0] AMODE_A0   = 2'd1;
  localparam logic [AMODE_W-1:0] AMODE_A1   = 2'd2;
  localparam logic [AMODE_W-1:0] AMODE_BAD  = 2'd3;

endpackage

FILE: sv/gcode_line_parser.sv
// channel   | ports                                   | accepted when
// ----------+-----------------------------------------+------------------------
// input     | in_valid, in_ready, in_char_in          | in_valid & in_ready
// result    | out_valid, out_ready, out_command_code, | out_valid & out_ready
//           | out_a_mode, out_x/y_hundredths          |
// a character other than line feed is written to the line ram; leading characters other than G or M are dropped
// a line feed on a non-empty line starts the walk: one ram read per stored
// character through the single read port, the read pipe drains, then scale, then emit
// reset is synchronous and active low; it empties the line, the ram is not cleared
// a pending result stalls only the emit step; no characters are taken while it waits there
//
// gcode_line_parser: top level, line store in gclp_ram and the token walk
// depends on gclp_pkg and gclp_ram
module gcode_line_parser import gclp_pkg::*; #(
  parameter int LINE_CHARS  = LINE_CHARS_DEF,
  parameter int TOKEN_CHARS = TOKEN_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [CODE_W-1:0]  out_command_code,
  output logic [AMODE_W-1:0]        out_a_mode,
  output logic signed [COORD_W-1:0] out_x_hundredths,
  output logic signed [COORD_W-1:0] out_y_hundredths
);

  localparam int AW = $clog2(LINE_CHARS);
  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int PW = $clog2(TOKEN_CHARS + 1);
  localparam logic [CW-1:0] SLOT_LAST = CW'(LINE_CHARS - 1);
  localparam logic [CW-1:0] SLOT_FULL = CW'(LINE_CHARS);
  localparam logic [PW-1:0] POS_MAX   = PW'(TOKEN_CHARS);

  // token positions of interest
  localparam logic [2:0] TOK_CMD  = 3'd0;
  localparam logic [2:0] TOK_X    = 3'd1;
  localparam logic [2:0] TOK_AM   = 3'd3;
  localparam logic [2:0] TOK_DONE = 3'd4;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_SCALE, ST_EMIT} state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        rd_idx_r;
  logic                 dv_r;
  logic [2:0]           tok_r;
  logic [PW-1:0]        pos_r;
  logic [7:0]           head_r;
  logic [7:0]           c1_r, c2_r, a3c1_r;
  logic                 has1_r, has2_r, a3a_r, has_a3_r;
  logic                 gate_r [2];
  logic                 neg_r  [2];
  logic [COORD_W-1:0]   acc_r  [2];
  logic                 out_valid_r;
  logic [CODE_W-1:0]    code_r;
  logic [AMODE_W-1:0]   amode_r;
  logic [COORD_W-1:0]   x_r, y_r;

  logic                 in_acc, is_lf, keep_char, wr_en, rd_en;
  logic [CW-1:0]        wslot;
  logic [7:0]           rc;
  logic                 is_sep, is_dig;
  logic [3:0]           dig;
  logic                 is_g, is_m;
  logic signed [13:0]   d1_s, d2_s, n_s, code_full;
  logic [CODE_W-1:0]    code_nxt;
  logic [AMODE_W-1:0]   amode_nxt;
  logic [COORD_W-1:0]   x_nxt, y_nxt;

  // input side: characters are only taken while no walk is running
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_lf     = (in_char_in == CH_LF);
  assign keep_char = (count_r != '0) || (in_char_in == CH_G) || (in_char_in == CH_M);
  assign wr_en     = in_acc && !is_lf && keep_char;
  // once full, the last slot is overwritten
  assign wslot     = (count_r >= SLOT_FULL) ? SLOT_LAST : count_r;

  // walk reads; writes only happen in idle so no access overlap
  assign rd_en = (state_r == ST_WALK) && (rd_idx_r < count_r);

  gclp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CHARS)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wslot[AW-1:0]),
    .wdata (in_char_in),
    .re    (rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rc)
  );

  // character classes of the read-back byte
  assign is_sep = (rc == CH_NUL) || (rc == CH_SP);
  assign is_dig = (rc >= CH_0) && (rc < CH_COLON);
  assign dig    = 4'(rc - CH_0);

  assign is_g = (head_r == CH_G);
  assign is_m = (head_r == CH_M);

  // command code: a missing second character counts as character code -1, digit -49
  always_comb begin
    d1_s = has1_r ? ($signed({6'b0, c1_r}) - 14'sd48) : -14'sd49;
    d2_s = $signed({6'b0, c2_r}) - 14'sd48;
    n_s  = has2_r ? 14'(d1_s * 14'sd10 + d2_s) : d1_s;
    if (is_g) begin
      code_full = n_s + 14'(CODE_OFS_G);
    end else if (is_m) begin
      code_full = n_s + 14'(CODE_OFS_M);
    end else begin
      code_full = '0;
    end
    code_nxt = code_full[CODE_W-1:0];
  end

  // a mode from the fourth token
  always_comb begin
    amode_nxt = AMODE_NONE;
    if (a3a_r && has_a3_r) begin
      if (a3c1_r == CH_0) begin
        amode_nxt = AMODE_A0;
      end else if (a3c1_r == CH_1) begin
        amode_nxt = AMODE_A1;
      end
    end
  end

  // sign of the coordinates
  assign x_nxt = neg_r[0] ? COORD_W'(0 - acc_r[0]) : acc_r[0];
  assign y_nxt = neg_r[1] ? COORD_W'(0 - acc_r[1]) : acc_r[1];

  // state, line count, token walk and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      tok_r       <= TOK_CMD;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; the emit step refills the register itself
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (wr_en) begin
            count_r <= wslot + 1'b1;
          end
          if (in_acc && is_lf && (count_r != '0)) begin
            state_r  <= ST_WALK;
            rd_idx_r <= '0;
            dv_r     <= 1'b0;
            tok_r    <= TOK_CMD;
            pos_r    <= '0;
            head_r   <= CH_NUL;
            has1_r   <= 1'b0;
            has2_r   <= 1'b0;
            a3a_r    <= 1'b0;
            has_a3_r <= 1'b0;
            for (int k = 0; k < 2; k++) begin
              gate_r[k] <= 1'b0;
              neg_r[k]  <= 1'b0;
              acc_r[k]  <= '0;
            end
          end
        end
        ST_WALK: begin
          dv_r <= rd_en;
          if (rd_en) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          if (dv_r) begin
            if (is_sep) begin
              if (tok_r < TOK_DONE) begin
                tok_r <= tok_r + 3'd1;
              end
              pos_r <= '0;
            end else if (pos_r < POS_MAX) begin
              pos_r <= pos_r + 1'b1;
              case (tok_r)
                TOK_CMD: begin
                  if (pos_r == PW'(0)) begin
                    head_r <= rc;
                  end
                  if (pos_r == PW'(1)) begin
                    c1_r   <= rc;
                    has1_r <= 1'b1;
                  end
                  if (pos_r == PW'(2)) begin
                    c2_r   <= rc;
                    has2_r <= 1'b1;
                  end
                end
                TOK_AM: begin
                  if (pos_r == PW'(0)) begin
                    a3a_r <= (rc == CH_A);
                  end
                  if (pos_r == PW'(1)) begin
                    a3c1_r   <= rc;
                    has_a3_r <= 1'b1;
                  end
                end
                default: ;
              endcase
              // coordinate lanes: gate, sign and decimal accumulate
              for (int k = 0; k < 2; k++) begin
                if (tok_r == TOK_X + 3'(k)) begin
                  if (pos_r == PW'(0)) begin
                    gate_r[k] <= (rc > CH_MINUS);
                  end
                  if (pos_r == PW'(1)) begin
                    neg_r[k] <= (rc == CH_MINUS);
                  end
                  if (is_dig) begin
                    acc_r[k] <= COORD_W'((acc_r[k] << 3) + (acc_r[k] << 1)
                                         + COORD_W'(dig));
                  end
                end
              end
            end
          end
          if ((rd_idx_r == count_r) && !dv_r) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          // ungated coordinates are cleared; whole units on non-g lines become hundredths
          for (int k = 0; k < 2; k++) begin
            if (!gate_r[k]) begin
              acc_r[k] <= '0;
            end else if (!is_g) begin
              acc_r[k] <= COORD_W'((acc_r[k] << 6) + (acc_r[k] << 5) + (acc_r[k] << 2));
            end
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            code_r      <= code_nxt;
            amode_r     <= amode_nxt;
            x_r         <= x_nxt;
            y_r         <= y_nxt;
            out_valid_r <= 1'b1;
            count_r     <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_code = $signed(code_r);
  assign out_a_mode       = amode_r;
  assign out_x_hundredths = $signed(x_r);
  assign out_y_hundredths = $signed(y_r);

endmodule

FILE: sv/gclp_ram.sv
// gclp_ram: generic single write port, single read port ram with registered read
// no dependencies; used by gcode_line_parser for the line store
module gclp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/gclp_checker.sv
// gclp_checker: port-level assertions on gcode_line_parser, bound to the top level
// depends on gclp_pkg and gcode_line_parser
module gclp_checker import gclp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [7:0]                in_char_in,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [CODE_W-1:0]  out_command_code,
  input logic [AMODE_W-1:0]        out_a_mode,
  input logic signed [COORD_W-1:0] out_x_hundredths,
  input logic signed [COORD_W-1:0] out_y_hundredths
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_code)
      && $stable(out_x_hundredths) && $stable(out_y_hundredths) && $stable(out_a_mode))
    else $error("stalled result changed");

  // only a line feed request can start a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_char_in != CH_LF) && !out_valid |=> !out_valid)
    else $error("result raised by a non line feed request");

  // a mode is never the unused code
  a_amode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_a_mode != AMODE_BAD))
    else $error("invalid a mode on result");

endmodule

bind gcode_line_parser gclp_checker u_gclp_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for gcode_line_parser, feeds text lines one character at a time
// predicts each parsed command from its own line store; depends on gclp_pkg and the parser rtl
module tb_top;
  import gclp_pkg::*;

  localparam int LINE_LEN   = LINE_CHARS_DEF;
  localparam int TOKEN_LEN  = TOKEN_CHARS_DEF;
  localparam int TOKENS     = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = LINE_LEN + 16;

  typedef struct packed {
    logic signed [CODE_W-1:0]  code;
    logic [AMODE_W-1:0]        a_mode;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } parsed_line_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_char_in = 8'd0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic signed [CODE_W-1:0]  out_command_code;
  logic [AMODE_W-1:0]        out_a_mode;
  logic signed [COORD_W-1:0] out_x_hundredths;
  logic signed [COORD_W-1:0] out_y_hundredths;

  // predicted line state
  logic [7:0] line_buf [LINE_LEN];
  int line_len = 0;
  bit line_overran = 1'b0;
  logic [7:0] tok_chars [TOKENS][TOKEN_LEN];
  int tok_lens [TOKENS];

  parsed_line_t pending_lines[$];
  logic [7:0] line_chars[$];

  bit steady_flow = 1'b0;
  int error_count = 0;
  int chars_sent = 0;
  int lines_sent = 0;
  int results_checked = 0;
  int overrun_lines = 0;
  int a0_lines = 0;
  int a1_lines = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  gcode_line_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code),
    .out_a_mode       (out_a_mode),
    .out_x_hundredths (out_x_hundredths),
    .out_y_hundredths (out_y_hundredths)
  );

  always #5 clk = ~clk;

  // character b of token a, -1 when absent
  function automatic int char_of(input int a, input int b);
    if (b >= tok_lens[a]) return -1;
    return int'(tok_chars[a][b]);
  endfunction

  // all digits of a token as one number, gated, scaled and signed
  function automatic logic [COORD_W-1:0] coord_of(input int a, input bit is_g);
    longint unsigned v;
    longint unsigned w;
    int c;
    v = 0;
    w = 1;
    if (char_of(a, 0) > int'(CH_MINUS)) begin
      for (int j = tok_lens[a] - 1; j >= 0; j--) begin
        c = char_of(a, j);
        if (c >= int'(CH_0) && c < int'(CH_COLON)) begin
          v += longint'(c - int'(CH_0)) * w;
          w *= 10;
        end
      end
    end
    if (!is_g) v *= 100;
    if (char_of(a, 1) == int'(CH_MINUS)) v = 0 - v;
    return v[COORD_W-1:0];
  endfunction

  // split the stored line into tokens and work out the command
  function automatic parsed_line_t parse_line();
    parsed_line_t p;
    int i;
    int n;
    int head;
    int code;
    bit is_g;
    i = 0;
    for (int a = 0; a < TOKENS; a++) begin
      n = 0;
      while (i < line_len && line_buf[i] != CH_NUL && line_buf[i] != CH_SP) begin
        if (n < TOKEN_LEN) begin
          tok_chars[a][n] = line_buf[i];
          n++;
        end
        i++;
      end
      tok_lens[a] = n;
      i++;
    end
    head = char_of(0, 0);
    is_g = (head == int'(CH_G));
    code = 0;
    if (is_g || head == int'(CH_M)) begin
      code = char_of(0, 1) - int'(CH_0);
      if (char_of(0, 2) != -1) code = code * 10 + (char_of(0, 2) - int'(CH_0));
      code += is_g ? CODE_OFS_G : CODE_OFS_M;
    end
    p.code = code[CODE_W-1:0];
    p.a_mode = AMODE_NONE;
    if (char_of(3, 0) == int'(CH_A)) begin
      if (char_of(3, 1) == int'(CH_0)) p.a_mode = AMODE_A0;
      else if (char_of(3, 1) == int'(CH_1)) p.a_mode = AMODE_A1;
    end
    p.x = coord_of(1, is_g);
    p.y = coord_of(2, is_g);
    return p;
  endfunction

  // update the predicted line with one accepted character
  function automatic void take_char(input logic [7:0] c);
    parsed_line_t p;
    if (c != CH_LF) begin
      if (line_len >= LINE_LEN) begin
        line_len = LINE_LEN - 1;
        line_overran = 1'b1;
      end
      if (line_len == 0 && c != CH_M && c != CH_G) return;
      line_buf[line_len] = c;
      line_len++;
    end else if (line_len != 0) begin
      p = parse_line();
      pending_lines.push_back(p);
      if (p.a_mode == AMODE_A0) a0_lines++;
      if (p.a_mode == AMODE_A1) a1_lines++;
      if (line_overran) overrun_lines++;
      line_overran = 1'b0;
      line_len = 0;
    end
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF) b = 8'd11;
    return b;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  // one coordinate-like token: mostly a letter, an optional sign and some digits
  function automatic void add_coord_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) line_chars.push_back($urandom_range(0, 1) ? "X" : "Y");
    else if (r < 70) line_chars.push_back(CH_MINUS);
    else if (r < 85) line_chars.push_back(rand_digit());
    else line_chars.push_back(rand_byte());
    if ($urandom_range(0, 9) < 4) line_chars.push_back(CH_MINUS);
    repeat ($urandom_range(0, 11)) begin
      if ($urandom_range(0, 9) == 0) line_chars.push_back(rand_byte());
      else line_chars.push_back(rand_digit());
    end
  endfunction

  // build one random line, mostly well formed, ending in a line feed
  function automatic void gen_line(input bit long_line);
    int r;
    int ntok;
    int target;
    line_chars.delete();
    r = $urandom_range(0, 99);
    if (r < 4) begin
      line_chars.push_back(CH_LF);
      return;
    end
    if (r < 10) repeat ($urandom_range(1, 3)) line_chars.push_back(rand_byte());
    line_chars.push_back($urandom_range(0, 1) ? CH_G : CH_M);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 9) == 0) line_chars.push_back(rand_byte());
      else line_chars.push_back(rand_digit());
    end
    ntok = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 5);
    for (int t = 1; t <= ntok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 80) line_chars.push_back(CH_SP);
      else if (r < 90) begin
        line_chars.push_back(CH_SP);
        line_chars.push_back(CH_SP);
      end else line_chars.push_back(CH_NUL);
      if (t == 3 && $urandom_range(0, 3) != 0) begin
        line_chars.push_back($urandom_range(0, 9) == 0 ? rand_byte() : CH_A);
        r = $urandom_range(0, 9);
        line_chars.push_back(r < 4 ? CH_0 : r < 8 ? CH_1 : rand_byte());
      end else add_coord_token();
    end
    if (long_line) begin
      target = LINE_LEN + $urandom_range(2, 12);
      while (line_chars.size() < target) begin
        r = $urandom_range(0, 9);
        line_chars.push_back(r < 5 ? rand_digit() : r < 7 ? CH_SP : rand_byte());
      end
    end
    line_chars.push_back(CH_LF);
  endfunction

  // offer one character and wait until the parser takes it
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (!in_ready);
    take_char(c);
    chars_sent++;
    if (c == CH_LF) lines_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line_chars();
    foreach (line_chars[i]) send_char(line_chars[i]);
  endtask

  // junk before a line is dropped, a bare line feed gives nothing
  task automatic test_rejected_heads();
    send_char(8'hFF);
    send_char(CH_NUL);
    send_str("x");
    send_char(CH_LF);
  endtask

  // heads of one and two characters
  task automatic test_short_heads();
    send_str("G");
    send_char(CH_LF);
    send_str("M3");
    send_char(CH_LF);
  endtask

  // signs, empty tokens, the coordinate gate, a zero byte and both a modes
  task automatic test_token_fields();
    send_str("M7 Y-9  A1");
    send_char(CH_LF);
    send_str("G12 -5 X");
    send_char(CH_NUL);
    send_str("A0");
    send_char(CH_LF);
  endtask

  task automatic run_random_lines(input int n_chars, input bit long_lines);
    int start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      gen_line(long_lines && $urandom_range(0, 2) != 0);
      send_line_chars();
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    run_random_lines(250, 1'b0);
    steady_flow = 1'b0;
  endtask

  // random gaps and stalls on both sides
  task automatic test_random_idle();
    run_random_lines(750, 1'b0);
  endtask

  // mostly lines longer than the store
  task automatic test_overrun_lines();
    run_random_lines(150, 1'b1);
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    end
  end

  // compare each result request with the oldest predicted command
  always @(posedge clk) begin : check_results
    parsed_line_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        note_error($sformatf("unexpected result: code %0d a %0d x %0d y %0d",
                             out_command_code, out_a_mode, out_x_hundredths,
                             out_y_hundredths));
      end else begin
        want = pending_lines.pop_front();
        results_checked++;
        if (out_command_code !== want.code || out_a_mode !== want.a_mode ||
            out_x_hundredths !== want.x || out_y_hundredths !== want.y)
          note_error($sformatf(
            "mismatch: exp code %0d a %0d x %0d y %0d, got code %0d a %0d x %0d y %0d",
            want.code, want.a_mode, want.x, want.y, out_command_code, out_a_mode,
            out_x_hundredths, out_y_hundredths));
      end
    end
  end

  // watchdog on cycles where no request moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_rejected_heads();
    test_short_heads();
    test_token_fields();
    test_back_to_back();
    test_random_idle();
    test_overrun_lines();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("%0d characters sent in %0d lines, %0d parsed commands checked",
             chars_sent, lines_sent, results_checked);
    $display("%0d lines overran the store, %0d with A0 and %0d with A1, %0d errors",
             overrun_lines, a0_lines, a1_lines, error_count);
    if (error_count == 0 && pending_lines.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
